/* rtl/core/fism_pkg.sv */
package fism_pkg;

    localparam int OP_W   = 2;
    localparam int ADDR_W = 32;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 6;
    localparam int STS_W  = 2;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd2;
    localparam logic [STS_W-1:0] STS_BAD   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EVAL,
        ST_MOVE,
        ST_APPEND,
        ST_SPLIT,
        ST_RDWAIT,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [CNT_W-1:0]  entry_count;
        logic [ADDR_W-1:0] entry_low;
        logic [ADDR_W-1:0] entry_high;
    } t_result;

endpackage

/* rtl/core/fism_req_if.sv */
interface fism_req_if;
    import fism_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] range_low;
    logic [ADDR_W-1:0] range_high;
    logic [IDX_W-1:0]  entry_index;

    modport source (
        output valid, op, range_low, range_high, entry_index,
        input  ready
    );

    modport sink (
        input  valid, op, range_low, range_high, entry_index,
        output ready
    );
endinterface

/* rtl/core/fism_rsp_if.sv */
interface fism_rsp_if;
    import fism_pkg::*;

    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic [CNT_W-1:0]  entry_count;
    logic [ADDR_W-1:0] entry_low;
    logic [ADDR_W-1:0] entry_high;

    modport source (
        output valid, status, entry_count, entry_low, entry_high,
        input  ready
    );

    modport sink (
        input  valid, status, entry_count, entry_low, entry_high,
        output ready
    );
endinterface

/* rtl/core/free_interval_set_manager.sv */
// Insert and reserve walk the held entries through the table memory, one entry per
// cycle except where a step moves the last entry into a freed slot, and end with an
// append or split write; a read fetches one entry. One item is worked on at a time;
// the next is taken once the result is in the output register, which holds it until
// transfer.
// Synchronous active-low reset empties the table; entry contents are not cleared.
module free_interval_set_manager #(
    parameter int MAX_ENTRIES = 32,
    parameter int PAGE_BITS   = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fism_req_if.sink   i_req,
    fism_rsp_if.source o_rsp
);
    import fism_pkg::*;

    logic    res_valid;
    logic    res_ready;
    t_result res;

    fism_walk #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .PAGE_BITS   (PAGE_BITS)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    fism_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (res),
        .o_rsp   (o_rsp)
    );
endmodule

/* rtl/core/fism_ram.sv */
module fism_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/fism_walk.sv */
module fism_walk #(
    parameter int MAX_ENTRIES = 32,
    parameter int PAGE_BITS   = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fism_req_if.sink          i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output fism_pkg::t_result o_res
);
    import fism_pkg::*;

    localparam int PW = ADDR_W - PAGE_BITS;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int EW = 2 * PW;
    localparam logic [ADDR_W:0] PMASK = (ADDR_W+1)'((64'd1 << PAGE_BITS) - 64'd1);

    t_state             r_state, n_state;
    logic [OP_W-1:0]    r_op, n_op;
    logic [ADDR_W-1:0]  r_lo_b, n_lo_b;
    logic [ADDR_W-1:0]  r_hi_b, n_hi_b;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [PW-1:0]      r_lo, n_lo;
    logic [PW-1:0]      r_hi, n_hi;
    logic [PW-1:0]      r_e, n_e;
    logic [CW-1:0]      r_m, n_m;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [STS_W-1:0]   r_status, n_status;
    logic [ADDR_W-1:0]  r_elo, n_elo;
    logic [ADDR_W-1:0]  r_ehi, n_ehi;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [EW-1:0]      ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [EW-1:0]      ram_rdata;

    logic [ADDR_W:0]    w_sum_lo, w_sum_hi;
    logic [PW:0]        w_fp, w_lp1, w_lp1_dec;
    logic               w_ins_empty;
    logic [PW-1:0]      w_rl, w_rh;
    logic               w_read_ok;
    logic [PW-1:0]      w_s, w_e;
    logic               w_absorb, w_overlap, w_split, w_drop;
    logic [CW-1:0]      w_cnt_dec, w_m_src, w_m_dec;
    logic               w_move, w_full;
    t_state             w_adv_state;

    fism_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_sum_lo    = {1'b0, r_lo_b} + PMASK;
    assign w_sum_hi    = {1'b0, r_hi_b} + (ADDR_W+1)'(1);
    assign w_fp        = w_sum_lo[ADDR_W:PAGE_BITS];
    assign w_lp1       = w_sum_hi[ADDR_W:PAGE_BITS];
    assign w_lp1_dec   = w_lp1 - (PW+1)'(1);
    assign w_ins_empty = w_fp[PW] || (w_lp1 == '0) || (w_fp >= w_lp1);
    assign w_rl        = r_lo_b[ADDR_W-1:PAGE_BITS];
    assign w_rh        = r_hi_b[ADDR_W-1:PAGE_BITS];
    assign w_read_ok   = (32'(r_idx) < 32'(r_cnt)) && (32'(r_idx) < MAX_ENTRIES);

    assign w_s = ram_rdata[EW-1:PW];
    assign w_e = ram_rdata[PW-1:0];

    assign w_absorb  = !((({1'b0, r_hi} + (PW+1)'(1)) < {1'b0, w_s}) ||
                         (({1'b0, w_e} + (PW+1)'(1)) < {1'b0, r_lo}));
    assign w_overlap = (w_s <= r_hi) && (r_lo <= w_e);
    assign w_split   = w_overlap && (w_s < r_lo) && (r_hi < w_e);
    assign w_drop    = w_overlap && !(w_s < r_lo) && !(r_hi < w_e);
    assign w_cnt_dec = r_cnt - CW'(1);
    assign w_move    = w_cnt_dec > r_m;
    assign w_full    = r_cnt >= CW'(MAX_ENTRIES);
    assign w_m_src   = (r_state == ST_DECODE) ? r_cnt : r_m;
    assign w_m_dec   = w_m_src - CW'(1);

    always_comb begin
        if (w_m_src == '0) begin
            w_adv_state = (r_op == OP_INSERT) ? ST_APPEND : ST_RESP;
        end else begin
            w_adv_state = ST_EVAL;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (r_op)
                    OP_INSERT:  n_state = w_ins_empty ? ST_RESP : w_adv_state;
                    OP_RESERVE: n_state = (r_lo_b > r_hi_b) ? ST_RESP : w_adv_state;
                    OP_READ:    n_state = w_read_ok ? ST_RDWAIT : ST_RESP;
                    default:    n_state = ST_RESP;
                endcase
            end
            ST_EVAL: begin
                if (r_op == OP_INSERT) begin
                    n_state = (w_absorb && w_move) ? ST_MOVE : w_adv_state;
                end else if (w_split) begin
                    n_state = ST_SPLIT;
                end else begin
                    n_state = (w_drop && w_move) ? ST_MOVE : w_adv_state;
                end
            end
            ST_MOVE:   n_state = w_adv_state;
            ST_APPEND: n_state = ST_RESP;
            ST_SPLIT:  n_state = ST_RESP;
            ST_RDWAIT: n_state = ST_RESP;
            ST_RESP: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_op      = r_op;
        n_lo_b    = r_lo_b;
        n_hi_b    = r_hi_b;
        n_idx     = r_idx;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_e       = r_e;
        n_m       = r_m;
        n_cnt     = r_cnt;
        n_status  = r_status;
        n_elo     = r_elo;
        n_ehi     = r_ehi;
        ram_we    = 1'b0;
        ram_waddr = r_m[IW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = w_m_dec[IW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_op   = i_req.op;
                    n_lo_b = i_req.range_low;
                    n_hi_b = i_req.range_high;
                    n_idx  = i_req.entry_index;
                end
            end
            ST_DECODE: begin
                n_status = STS_DONE;
                n_elo    = '0;
                n_ehi    = '0;
                n_m      = w_m_dec;
                unique case (r_op)
                    OP_INSERT: begin
                        if (w_ins_empty) begin
                            n_status = STS_EMPTY;
                        end else begin
                            n_lo = w_fp[PW-1:0];
                            n_hi = w_lp1_dec[PW-1:0];
                        end
                    end
                    OP_RESERVE: begin
                        if (r_lo_b > r_hi_b) begin
                            n_status = STS_EMPTY;
                        end else begin
                            n_lo = w_rl;
                            n_hi = w_rh;
                        end
                    end
                    OP_READ: begin
                        ram_raddr = IW'(r_idx);
                        if (!w_read_ok) begin
                            n_status = STS_BAD;
                        end
                    end
                    default: n_status = STS_BAD;
                endcase
            end
            ST_EVAL: begin
                n_m = w_m_dec;
                if (r_op == OP_INSERT) begin
                    if (w_absorb) begin
                        n_lo  = (w_s < r_lo) ? w_s : r_lo;
                        n_hi  = (w_e > r_hi) ? w_e : r_hi;
                        n_cnt = w_cnt_dec;
                        if (w_move) begin
                            n_m       = r_m;
                            ram_raddr = w_cnt_dec[IW-1:0];
                        end
                    end
                end else if (w_overlap) begin
                    if (w_s < r_lo) begin
                        ram_we    = 1'b1;
                        ram_wdata = {w_s, r_lo - PW'(1)};
                        n_e       = w_e;
                    end else if (r_hi < w_e) begin
                        ram_we    = 1'b1;
                        ram_wdata = {r_hi + PW'(1), w_e};
                    end else begin
                        n_cnt = w_cnt_dec;
                        if (w_move) begin
                            n_m       = r_m;
                            ram_raddr = w_cnt_dec[IW-1:0];
                        end
                    end
                end
            end
            ST_MOVE: begin
                ram_we = 1'b1;
                n_m    = w_m_dec;
            end
            ST_APPEND: begin
                ram_waddr = r_cnt[IW-1:0];
                ram_wdata = {r_lo, r_hi};
                if (w_full) begin
                    n_status = STS_FULL;
                end else begin
                    ram_we = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                end
            end
            ST_SPLIT: begin
                ram_waddr = r_cnt[IW-1:0];
                ram_wdata = {r_hi + PW'(1), r_e};
                if (w_full) begin
                    n_status = STS_FULL;
                end else begin
                    ram_we = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                end
            end
            ST_RDWAIT: begin
                n_elo = {w_s, {PAGE_BITS{1'b0}}};
                n_ehi = {w_e, {PAGE_BITS{1'b1}}};
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_lo_b   <= n_lo_b;
        r_hi_b   <= n_hi_b;
        r_idx    <= n_idx;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_e      <= n_e;
        r_m      <= n_m;
        r_status <= n_status;
        r_elo    <= n_elo;
        r_ehi    <= n_ehi;
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_res_valid       = (r_state == ST_RESP);
    assign o_res.status      = r_status;
    assign o_res.entry_count = CNT_W'(r_cnt);
    assign o_res.entry_low   = r_elo;
    assign o_res.entry_high  = r_ehi;
endmodule

/* rtl/core/fism_out_reg.sv */
module fism_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  fism_pkg::t_result i_res,
    fism_rsp_if.source        o_rsp
);
    import fism_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_ready = !r_valid || o_rsp.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.status      = r_res.status;
    assign o_rsp.entry_count = r_res.entry_count;
    assign o_rsp.entry_low   = r_res.entry_low;
    assign o_rsp.entry_high  = r_res.entry_high;
endmodule

/* rtl/core/fism_checker.sv */
module fism_checker #(
    parameter int PAGE_BITS = 12
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [5:0]  i_rsp_entry_count,
    input logic [31:0] i_rsp_entry_low,
    input logic [31:0] i_rsp_entry_high
);
    import fism_pkg::*;

    // The block never takes two items in consecutive cycles.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("input ready did not drop after a transfer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_status) &&
            $stable(i_rsp_entry_count) && $stable(i_rsp_entry_low) &&
            $stable(i_rsp_entry_high)))
        else $error("stalled result changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != STS_DONE)) |->
            ((i_rsp_entry_low == '0) && (i_rsp_entry_high == '0)))
        else $error("entry fields nonzero on a failed operation");

    // A returned entry always spans whole pages.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && ((i_rsp_entry_low != '0) || (i_rsp_entry_high != '0))) |->
            ((i_rsp_entry_low[PAGE_BITS-1:0] == '0) &&
             (i_rsp_entry_high[PAGE_BITS-1:0] == '1)))
        else $error("returned entry not page aligned");
endmodule

bind free_interval_set_manager fism_checker #(
    .PAGE_BITS (PAGE_BITS)
) u_fism_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_entry_count (o_rsp.entry_count),
    .i_rsp_entry_low   (o_rsp.entry_low),
    .i_rsp_entry_high  (o_rsp.entry_high)
);

/* sim/tb_free_interval_set_manager.sv */
module tb_free_interval_set_manager;
    timeunit 1ns;
    timeprecision 1ps;

    import fism_pkg::*;

    localparam int MAX_SLOTS = 32;
    localparam int PAGE_BITS = 12;
    localparam int PG_W      = ADDR_W - PAGE_BITS;
    localparam int CYCLE_LIMIT = 1_200_000;

    localparam logic [PAGE_BITS-1:0] PAGE_ONES  = '1;
    localparam longint unsigned      PAGE_COUNT = 64'd1 << PG_W;
    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    fism_req_if req_bus ();
    fism_rsp_if rsp_bus ();

    free_interval_set_manager #(
        .MAX_ENTRIES(MAX_SLOTS),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [PG_W-1:0] free_first_pg [MAX_SLOTS];
    logic [PG_W-1:0] free_last_pg  [MAX_SLOTS];
    int              free_count = 0;

    t_result replies_due [$];
    int      fail_count      = 0;
    bit      req_steady      = 1'b0;
    bit      rsp_steady      = 1'b0;
    int      rsp_hold_cycles = 0;

    function automatic void remove_interval(input int slot);
        free_count--;
        if (free_count > slot) begin
            free_first_pg[slot] = free_first_pg[free_count];
            free_last_pg[slot]  = free_last_pg[free_count];
        end
    endfunction

    function automatic logic [STS_W-1:0] merge_free_range(input logic [ADDR_W-1:0] lo_b,
                                                          input logic [ADDR_W-1:0] hi_b);
        longint unsigned first_pg;
        longint unsigned end_pg_p1;
        int unsigned     lo;
        int unsigned     hi;
        first_pg  = lo_b;
        first_pg  = (first_pg + PAGE_ONES) >> PAGE_BITS;
        end_pg_p1 = hi_b;
        end_pg_p1 = (end_pg_p1 + 1) >> PAGE_BITS;
        if (first_pg >= PAGE_COUNT || end_pg_p1 == 0 || first_pg > end_pg_p1 - 1)
            return STS_EMPTY;
        lo = 32'(first_pg);
        hi = 32'(end_pg_p1 - 1);
        for (int slot = free_count - 1; slot >= 0; slot--) begin
            if (!(hi + 1 < free_first_pg[slot] || free_last_pg[slot] + 1 < lo)) begin
                if (free_first_pg[slot] < lo)
                    lo = free_first_pg[slot];
                if (free_last_pg[slot] > hi)
                    hi = free_last_pg[slot];
                remove_interval(slot);
            end
        end
        if (free_count < MAX_SLOTS) begin
            free_first_pg[free_count] = PG_W'(lo);
            free_last_pg[free_count]  = PG_W'(hi);
            free_count++;
            return STS_DONE;
        end
        return STS_FULL;
    endfunction

    function automatic logic [STS_W-1:0] carve_free_range(input logic [ADDR_W-1:0] lo_b,
                                                          input logic [ADDR_W-1:0] hi_b);
        logic [PG_W-1:0]  rl;
        logic [PG_W-1:0]  rh;
        logic [STS_W-1:0] sts;
        if (lo_b > hi_b)
            return STS_EMPTY;
        rl = lo_b[ADDR_W-1:PAGE_BITS];
        rh = hi_b[ADDR_W-1:PAGE_BITS];
        for (int slot = free_count - 1; slot >= 0; slot--) begin
            if (free_first_pg[slot] <= rh && rl <= free_last_pg[slot]) begin
                if (free_first_pg[slot] < rl) begin
                    if (rh < free_last_pg[slot]) begin
                        sts = STS_DONE;
                        if (free_count < MAX_SLOTS) begin
                            free_first_pg[free_count] = rh + 1'b1;
                            free_last_pg[free_count]  = free_last_pg[slot];
                            free_count++;
                        end else begin
                            sts = STS_FULL;
                        end
                        free_last_pg[slot] = rl - 1'b1;
                        return sts;
                    end
                    free_last_pg[slot] = rl - 1'b1;
                end else if (rh < free_last_pg[slot]) begin
                    free_first_pg[slot] = rh + 1'b1;
                end else begin
                    remove_interval(slot);
                end
            end
        end
        return STS_DONE;
    endfunction

    function automatic t_result predict_reply(input logic [OP_W-1:0]   op,
                                              input logic [ADDR_W-1:0] lo_b,
                                              input logic [ADDR_W-1:0] hi_b,
                                              input logic [IDX_W-1:0]  idx);
        t_result res;
        res = '0;
        case (op)
            OP_INSERT:  res.status = merge_free_range(lo_b, hi_b);
            OP_RESERVE: res.status = carve_free_range(lo_b, hi_b);
            OP_READ: begin
                if (idx < free_count) begin
                    res.status     = STS_DONE;
                    res.entry_low  = {free_first_pg[idx], {PAGE_BITS{1'b0}}};
                    res.entry_high = {free_last_pg[idx], PAGE_ONES};
                end else begin
                    res.status = STS_BAD;
                end
            end
            default: res.status = STS_BAD;
        endcase
        res.entry_count = CNT_W'(free_count);
        return res;
    endfunction

    function automatic logic [PAGE_BITS-1:0] page_offset(input bit at_end);
        case ($urandom_range(0, 3))
            0:       return at_end ? PAGE_ONES : '0;
            1:       return at_end ? PAGE_ONES - 1'b1 : PAGE_BITS'(1);
            2:       return at_end ? '0 : PAGE_ONES;
            default: return PAGE_BITS'($urandom);
        endcase
    endfunction

    function automatic void pick_range(input  int unsigned       span,
                                       output logic [ADDR_W-1:0] lo_b,
                                       output logic [ADDR_W-1:0] hi_b);
        int              sel;
        logic [PG_W-1:0] first_pg;
        logic [PG_W-1:0] last_pg;
        logic [ADDR_W-1:0] swap;
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            lo_b = $urandom;
            hi_b = $urandom;
            return;
        end
        if (sel == 1)
            first_pg = '1 - PG_W'($urandom_range(0, 40));
        else
            first_pg = PG_W'($urandom_range(0, span));
        last_pg = first_pg + PG_W'($urandom_range(0, 6));
        if (last_pg < first_pg)
            last_pg = '1;
        lo_b = {first_pg, page_offset(1'b0)};
        hi_b = {last_pg, page_offset(1'b1)};
        if (sel == 2) begin
            swap = lo_b;
            lo_b = hi_b;
            hi_b = swap;
        end
    endfunction

    task automatic send_cmd(input logic [OP_W-1:0]   op,
                            input logic [ADDR_W-1:0] lo_b,
                            input logic [ADDR_W-1:0] hi_b,
                            input logic [IDX_W-1:0]  idx);
        int gap;
        gap = req_steady ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.op          <= op;
        req_bus.range_low   <= lo_b;
        req_bus.range_high  <= hi_b;
        req_bus.entry_index <= idx;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        replies_due.push_back(predict_reply(op, lo_b, hi_b, idx));
    endtask

    task automatic send_random_cmd(input int unsigned span);
        int                sel;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] lo_b;
        logic [ADDR_W-1:0] hi_b;
        logic [IDX_W-1:0]  idx;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            op = OP_INSERT;
        else if (sel < 80)
            op = OP_RESERVE;
        else if (sel < 97)
            op = OP_READ;
        else
            op = OP_UNUSED;
        pick_range(span, lo_b, hi_b);
        if (free_count > 0 && $urandom_range(0, 1) == 1)
            idx = IDX_W'($urandom_range(0, free_count - 1));
        else
            idx = IDX_W'($urandom);
        send_cmd(op, lo_b, hi_b, idx);
    endtask

    task automatic wait_replies_drained();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        send_cmd(OP_INSERT,  32'h0000_0000, 32'hFFFF_FFFF, '0);
        send_cmd(OP_READ,    '0, '0, 5'd0);
        send_cmd(OP_RESERVE, 32'h0000_0000, 32'h0000_0000, '0);
        send_cmd(OP_RESERVE, 32'hFFFF_F000, 32'hFFFF_FFFF, '0);
        send_cmd(OP_RESERVE, 32'h0001_0000, 32'h0001_0FFF, '0);
        send_cmd(OP_READ,    '0, '0, 5'd0);
        send_cmd(OP_READ,    '0, '0, 5'd1);
        send_cmd(OP_READ,    '0, '0, 5'd2);
        send_cmd(OP_READ,    '0, '0, 5'd31);
        send_cmd(OP_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        // No whole page inside: below the end of page 0, past the top, within one page.
        send_cmd(OP_INSERT,  32'h0000_0000, 32'h0000_0FFE, '0);
        send_cmd(OP_INSERT,  32'hFFFF_F001, 32'hFFFF_FFFF, '0);
        send_cmd(OP_INSERT,  32'h0000_1001, 32'h0000_1FFF, '0);
        send_cmd(OP_RESERVE, 32'h0000_5000, 32'h0000_4FFF, '0);
        send_cmd(OP_RESERVE, 32'h0000_0000, 32'hFFFF_FFFF, '0);
        send_cmd(OP_READ,    '0, '0, 5'd0);
        send_cmd(OP_INSERT,  32'h0000_A000, 32'h0000_AFFF, '0);
        send_cmd(OP_INSERT,  32'h0000_C000, 32'h0000_CFFF, '0);
        send_cmd(OP_INSERT,  32'h0000_B000, 32'h0000_BFFF, '0);
        send_cmd(OP_READ,    '0, '0, 5'd0);
        send_cmd(OP_INSERT,  32'h0000_E800, 32'h0001_0FFF, '0);
        send_cmd(OP_INSERT,  32'h0000_D000, 32'h0000_EFFF, '0);
        send_cmd(OP_RESERVE, 32'h0000_B123, 32'h0000_B124, '0);
        send_cmd(OP_READ,    '0, '0, 5'd1);
        send_cmd(OP_INSERT,  32'h0000_0000, 32'hFFFF_FFFF, '0);
        wait_replies_drained();
    endtask

    // Fill the table past its capacity with separated intervals, then split and merge inside it.
    task automatic test_fill_and_carve(input int rounds);
        logic [PG_W-1:0] next_pg;
        int              width;
        repeat (rounds) begin
            send_cmd(OP_RESERVE, '0, '1, IDX_W'($urandom));
            next_pg = PG_W'($urandom_range(0, 3));
            repeat (34 + $urandom_range(0, 4)) begin
                width = $urandom_range(0, 3);
                send_cmd(OP_INSERT, {next_pg, {PAGE_BITS{1'b0}}},
                         {next_pg + PG_W'(width), PAGE_ONES}, IDX_W'($urandom));
                next_pg = next_pg + PG_W'(width + 2 + $urandom_range(0, 1));
            end
            repeat (24) send_random_cmd(int'(next_pg));
        end
        wait_replies_drained();
    endtask

    task automatic test_reply_backpressure();
        req_steady      = 1'b1;
        rsp_hold_cycles = 500;
        repeat (40) send_random_cmd(127);
        req_steady = 1'b0;
        wait_replies_drained();
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                req_steady = ($urandom_range(0, 4) == 0);
                rsp_steady = req_steady;
            end
            send_random_cmd(127);
        end
        req_steady = 1'b0;
        rsp_steady = 1'b0;
        wait_replies_drained();
    endtask

    initial begin : reply_sink
        int wait_cycles;
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            wait_cycles = rsp_steady ? 0 : $urandom_range(0, 13);
            if (rsp_hold_cycles != 0) begin
                wait_cycles     = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            if (wait_cycles > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge clk); while (!(rst_n === 1'b1 && rsp_bus.valid === 1'b1));
        end
    end

    always @(posedge clk) begin : reply_check
        t_result want;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (replies_due.size() == 0) begin
                $error("unexpected result transfer: status %0d, entry_count %0d",
                       rsp_bus.status, rsp_bus.entry_count);
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                if (rsp_bus.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, rsp_bus.status);
                    fail_count++;
                end
                if (rsp_bus.entry_count !== want.entry_count) begin
                    $error("entry_count mismatch: expected %0d, got %0d",
                           want.entry_count, rsp_bus.entry_count);
                    fail_count++;
                end
                if (rsp_bus.entry_low !== want.entry_low) begin
                    $error("entry_low mismatch: expected %h, got %h",
                           want.entry_low, rsp_bus.entry_low);
                    fail_count++;
                end
                if (rsp_bus.entry_high !== want.entry_high) begin
                    $error("entry_high mismatch: expected %h, got %h",
                           want.entry_high, rsp_bus.entry_high);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles_seen;
        cycles_seen = 0;
        while (cycles_seen < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles_seen++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        req_bus.valid       = 1'b0;
        req_bus.op          = OP_INSERT;
        req_bus.range_low   = '0;
        req_bus.range_high  = '0;
        req_bus.entry_index = '0;
        rst_n               = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_fill_and_carve(8);
        test_reply_backpressure();
        test_random_mix(1200);

        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
